// ===== design/csvt_pkg.sv =====
package csvt_pkg;

  // default sizing for the top level parameters
  localparam int MaxRowsDefault   = 1024;
  localparam int MaxColumnDefault = 255;

  // row limit register
  localparam int                CfgW         = 11;
  localparam logic [CfgW-1:0]   CfgRowsReset = 11'd1024;

  // output field widths
  localparam int RowOutW = 11;
  localparam int ColOutW = 8;

  // bundle queue between front and back
  localparam int QueueDepth = 4;
  localparam int QPtrW      = $clog2(QueueDepth);
  localparam int QCntW      = $clog2(QueueDepth + 1);

  // input op codes
  localparam logic OpByte = 1'b0;
  localparam logic OpEnd  = 1'b1;

  // special characters
  localparam logic [7:0] ChQuote = 8'h22;
  localparam logic [7:0] ChComma = 8'h2C;
  localparam logic [7:0] ChLf    = 8'h0A;
  localparam logic [7:0] ChCr    = 8'h0D;

  // end-of-input status codes
  localparam logic [1:0] StatusOk        = 2'd0;
  localparam logic [1:0] StatusNoHeader  = 2'd1;
  localparam logic [1:0] StatusOpenQuote = 2'd2;

  typedef enum logic [1:0] {
    KindByte,
    KindField,
    KindRecord,
    KindStatus
  } kind_e;

  typedef enum logic [1:0] {
    PhStart,
    PhUnquoted,
    PhQuoted,
    PhQuoteSeen
  } phase_e;

  // one accepted item's worth of results; result i has kind first_kind + i
  typedef struct packed {
    logic [1:0]         cnt;
    kind_e              first_kind;
    logic [7:0]         data;
    logic               hdr;
    logic [RowOutW-1:0] row;
    logic [ColOutW-1:0] col;
    logic [1:0]         status;
    logic [RowOutW-1:0] total;
  } bundle_t;

endpackage

// ===== design/csv_stream_tokenizer_unit.sv =====
// csv tokenizer: one byte or end-of-input request per cycle on the input side
// path: an accepted request is written into the bundle queue, then its results are loaded into the output register
// throughput: one request per cycle accepted while the 4-entry bundle queue has room;
//   one result per cycle delivered while out_ready_i takes it; a request can give 2 or 3 results
// reset: asynchronous, active low; clears parser, queue and output valid, row limit to 1024
module csv_stream_tokenizer_unit
  import csvt_pkg::*;
#(
  parameter int MaxRows        = MaxRowsDefault,
  parameter int MaxColumnIndex = MaxColumnDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // row limit register
  input  logic               cfg_we_i,
  input  logic [CfgW-1:0]    cfg_wdata_i,
  // byte request channel
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               op_i,
  input  logic [7:0]         in_byte_i,
  // result channel
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [1:0]         kind_o,
  output logic [7:0]         out_byte_o,
  output logic               is_header_o,
  output logic [RowOutW-1:0] row_number_o,
  output logic [ColOutW-1:0] column_number_o,
  output logic [1:0]         status_o,
  output logic               last_o
);

  // front to queue
  bundle_t push_bundle;
  logic    push;
  logic    q_full;
  // queue to back
  bundle_t head;
  logic    q_empty;
  logic    pop;

  // front: parser state machine, classifies each request into a result bundle
  csvt_front #(
    .MaxRows        (MaxRows),
    .MaxColumnIndex (MaxColumnIndex)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .op_i        (op_i),
    .in_byte_i   (in_byte_i),
    .q_full_i    (q_full),
    .push_o      (push),
    .bundle_o    (push_bundle)
  );

  // bundle queue, requests with no result never enter it
  csvt_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (push_bundle),
    .pop_i   (pop),
    .rdata_o (head),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  // back: unrolls each bundle into one result per cycle through the output register, while the output is taken
  csvt_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .head_i          (head),
    .empty_i         (q_empty),
    .pop_o           (pop),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .kind_o          (kind_o),
    .out_byte_o      (out_byte_o),
    .is_header_o     (is_header_o),
    .row_number_o    (row_number_o),
    .column_number_o (column_number_o),
    .status_o        (status_o),
    .last_o          (last_o)
  );

endmodule

// ===== design/csvt_front.sv =====
module csvt_front
  import csvt_pkg::*;
#(
  parameter int MaxRows        = MaxRowsDefault,
  parameter int MaxColumnIndex = MaxColumnDefault
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [CfgW-1:0] cfg_wdata_i,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic            op_i,
  input  logic [7:0]      in_byte_i,
  input  logic            q_full_i,
  output logic            push_o,
  output bundle_t         bundle_o
);

  localparam int RowW = $clog2(MaxRows + 1);
  localparam int ColW = $clog2(MaxColumnIndex + 1);
  localparam int LimW = (RowW > CfgW) ? RowW : CfgW;

  logic [CfgW-1:0] max_rows_q;
  phase_e          phase_q, phase_d;
  logic            swallow_q, swallow_d;
  logic            header_q, header_d;
  logic [RowW-1:0] rows_q, rows_d;
  logic [ColW-1:0] fcount_q, fcount_d;
  logic            nonempty_q, nonempty_d;
  logic            stopped_q, stopped_d;

  logic [LimW-1:0] cfg_ext, max_ext, limit;
  logic            accept;
  logic            rec_open;
  logic            do_content, do_field, do_rec;
  logic [1:0]      st_code;
  logic [RowW-1:0] cur_row;
  logic [RowW+RowOutW-1:0] cur_row_ext, tot_row_ext;
  logic [ColW+ColOutW-1:0] col_ext;
  logic            emit_status;

  assign cfg_ext = LimW'(max_rows_q);
  assign max_ext = LimW'(MaxRows);
  assign limit   = (cfg_ext < max_ext) ? cfg_ext : max_ext;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign rec_open   = (fcount_q != '0) || nonempty_q;
  assign cur_row    = header_q ? rows_q : '0;

  // classify the item
  always_comb begin
    do_content = 1'b0;
    do_field   = 1'b0;
    do_rec     = 1'b0;
    swallow_d  = swallow_q;
    phase_d    = phase_q;
    if (op_i == OpEnd) begin
      if (!stopped_q && phase_q != PhQuoted) begin
        do_rec = rec_open;
      end
    end else if (!stopped_q) begin
      swallow_d = 1'b0;
      if (!(swallow_q && in_byte_i == ChLf)) begin
        if (phase_q == PhQuoted) begin
          if (in_byte_i == ChQuote) begin
            phase_d = PhQuoteSeen;
          end else begin
            do_content = 1'b1;
          end
        end else if (phase_q == PhQuoteSeen && in_byte_i == ChQuote) begin
          do_content = 1'b1;
          phase_d    = PhQuoted;
        end else if (in_byte_i == ChComma) begin
          do_field = 1'b1;
          phase_d  = PhStart;
        end else if (in_byte_i == ChLf) begin
          do_rec = 1'b1;
        end else if (in_byte_i == ChCr) begin
          do_rec    = 1'b1;
          swallow_d = 1'b1;
        end else if (phase_q == PhStart && in_byte_i == ChQuote) begin
          phase_d = PhQuoted;
        end else begin
          do_content = 1'b1;
          phase_d    = PhUnquoted;
        end
      end
    end
  end

  // apply the parser effects
  always_comb begin
    header_d   = header_q;
    rows_d     = rows_q;
    fcount_d   = fcount_q;
    nonempty_d = nonempty_q;
    stopped_d  = stopped_q;
    if (do_content) begin
      nonempty_d = 1'b1;
    end
    if (do_field) begin
      if (fcount_q < ColW'(MaxColumnIndex)) begin
        fcount_d = fcount_q + ColW'(1);
      end
      nonempty_d = 1'b0;
    end
    if (do_rec) begin
      if (rec_open) begin
        if (!header_q) begin
          header_d = 1'b1;
        end else if (LimW'(rows_q) < limit) begin
          rows_d = rows_q + RowW'(1);
        end
      end
      if (header_d && LimW'(rows_d) >= limit) begin
        stopped_d = 1'b1;
      end
      fcount_d   = '0;
      nonempty_d = 1'b0;
    end
  end

  always_comb begin
    st_code = StatusOk;
    if (!stopped_q) begin
      if (phase_q == PhQuoted) begin
        st_code = StatusOpenQuote;
      end else if (!header_d) begin
        st_code = StatusNoHeader;
      end
    end
  end

  assign emit_status = (op_i == OpEnd);
  assign cur_row_ext = {{RowOutW{1'b0}}, cur_row};
  assign tot_row_ext = {{RowOutW{1'b0}}, rows_d};
  assign col_ext     = {{ColOutW{1'b0}}, fcount_q};

  // build the result bundle
  always_comb begin
    bundle_o            = '0;
    bundle_o.hdr        = !header_q;
    bundle_o.row        = cur_row_ext[RowOutW-1:0];
    bundle_o.col        = col_ext[ColOutW-1:0];
    bundle_o.total      = tot_row_ext[RowOutW-1:0];
    bundle_o.status     = st_code;
    bundle_o.first_kind = KindField;
    if (emit_status) begin
      if (do_rec && rec_open) begin
        bundle_o.cnt = 2'd3;
      end else begin
        bundle_o.cnt        = 2'd1;
        bundle_o.first_kind = KindStatus;
      end
    end else if (do_content) begin
      bundle_o.cnt        = 2'd1;
      bundle_o.first_kind = KindByte;
      bundle_o.data       = in_byte_i;
    end else if (do_field) begin
      bundle_o.cnt = 2'd1;
    end else if (do_rec && rec_open) begin
      bundle_o.cnt = 2'd2;
    end
  end

  assign push_o = accept && (bundle_o.cnt != 2'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_rows_q <= CfgRowsReset;
    end else if (cfg_we_i) begin
      max_rows_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PhStart;
      swallow_q  <= 1'b0;
      header_q   <= 1'b0;
      rows_q     <= '0;
      fcount_q   <= '0;
      nonempty_q <= 1'b0;
      stopped_q  <= 1'b0;
    end else if (accept) begin
      if (op_i == OpEnd) begin
        // end of input returns the parser to its reset state
        phase_q    <= PhStart;
        swallow_q  <= 1'b0;
        header_q   <= 1'b0;
        rows_q     <= '0;
        fcount_q   <= '0;
        nonempty_q <= 1'b0;
        stopped_q  <= 1'b0;
      end else begin
        phase_q    <= do_rec ? PhStart : phase_d;
        swallow_q  <= swallow_d;
        header_q   <= header_d;
        rows_q     <= rows_d;
        fcount_q   <= fcount_d;
        nonempty_q <= nonempty_d;
        stopped_q  <= stopped_d;
      end
    end
  end

endmodule

// ===== design/csvt_fifo.sv =====
module csvt_fifo
  import csvt_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  bundle_t wdata_i,
  input  logic    pop_i,
  output bundle_t rdata_o,
  output logic    full_o,
  output logic    empty_o
);

  bundle_t          mem_q [QueueDepth];
  logic [QPtrW-1:0] wptr_q, rptr_q;
  logic [QCntW-1:0] cnt_q;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == QCntW'(QueueDepth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= (wptr_q == QPtrW'(QueueDepth - 1)) ? '0 : wptr_q + QPtrW'(1);
      end
      if (do_pop) begin
        rptr_q <= (rptr_q == QPtrW'(QueueDepth - 1)) ? '0 : rptr_q + QPtrW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + QCntW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - QCntW'(1);
      end
    end
  end

endmodule

// ===== design/csvt_back.sv =====
module csvt_back
  import csvt_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  bundle_t            head_i,
  input  logic               empty_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [1:0]         kind_o,
  output logic [7:0]         out_byte_o,
  output logic               is_header_o,
  output logic [RowOutW-1:0] row_number_o,
  output logic [ColOutW-1:0] column_number_o,
  output logic [1:0]         status_o,
  output logic               last_o
);

  logic [1:0]         idx_q;
  logic               valid_q;
  kind_e              kind_q;
  logic [7:0]         byte_q;
  logic               hdr_q;
  logic [RowOutW-1:0] row_q;
  logic [ColOutW-1:0] col_q;
  logic [1:0]         status_q;
  logic               last_q;

  logic  load;
  kind_e kind_cur;
  logic  is_status;
  logic  is_last;

  assign load      = !empty_i && (!valid_q || out_ready_i);
  assign kind_cur  = kind_e'(head_i.first_kind + idx_q);
  assign is_status = (kind_cur == KindStatus);
  assign is_last   = (idx_q == head_i.cnt - 2'd1);
  assign pop_o     = load && is_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= '0;
    end else begin
      if (load) begin
        valid_q <= 1'b1;
        idx_q   <= is_last ? 2'd0 : idx_q + 2'd1;
      end else if (out_ready_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      kind_q   <= kind_cur;
      byte_q   <= (kind_cur == KindByte) ? head_i.data : 8'd0;
      hdr_q    <= is_status ? 1'b0 : head_i.hdr;
      row_q    <= is_status ? head_i.total : head_i.row;
      col_q    <= is_status ? '0 : head_i.col;
      status_q <= is_status ? head_i.status : StatusOk;
      last_q   <= is_last;
    end
  end

  assign out_valid_o     = valid_q;
  assign kind_o          = kind_q;
  assign out_byte_o      = byte_q;
  assign is_header_o     = hdr_q;
  assign row_number_o    = row_q;
  assign column_number_o = col_q;
  assign status_o        = status_q;
  assign last_o          = last_q;

endmodule

// ===== design/csvt_checker.sv =====
module csvt_checker
  import csvt_pkg::*;
(
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic [1:0]         kind_o,
  input logic [7:0]         out_byte_o,
  input logic               is_header_o,
  input logic [RowOutW-1:0] row_number_o,
  input logic [ColOutW-1:0] column_number_o,
  input logic [1:0]         status_o,
  input logic               last_o
);

  // a pending result holds until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(kind_o) && $stable(out_byte_o))
    else $error("result changed while stalled");

  // status closes its request
  a_status_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == KindStatus |-> last_o && !is_header_o && column_number_o == '0)
    else $error("status result malformed");

  // a field byte is the only result of its request
  a_byte_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == KindByte |-> last_o && status_o == StatusOk)
    else $error("field byte not single");

  // end of record not last is followed by the end-of-input status
  a_rec_then_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && kind_o == KindRecord && !last_o
      |=> out_valid_o && kind_o == KindStatus)
    else $error("flushed record not followed by status");

  // nonzero status only on status results
  a_status_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != StatusOk |-> kind_o == KindStatus)
    else $error("status on non-status result");

endmodule

bind csv_stream_tokenizer_unit csvt_checker u_checker (.*);

// ===== verif/tb_csv_stream_tokenizer_unit.sv =====
`timescale 1ns / 100ps

module tb_csv_stream_tokenizer_unit;
  import csvt_pkg::*;

  // run sizing
  localparam int CycleLimit   = 400000;
  localparam int SettleCycles = 6;    // margin for the block's pipeline
  localparam int TailCycles   = 20;
  localparam int HoldCycles   = 150;  // long output back-pressure stretch
  localparam int MaxCol       = MaxColumnDefault;

  // one expected or observed output event
  typedef struct packed {
    kind_e              kind;
    logic [7:0]         data;
    logic               hdr;
    logic [RowOutW-1:0] row;
    logic [ColOutW-1:0] col;
    logic [1:0]         status;
    logic               last;
  } token_t;

  // one directed request, with its result typed in where it is obvious
  typedef struct packed {
    logic       op;
    logic [7:0] data;
    logic       typed;
    token_t     want;
  } probe_t;

  localparam token_t NoToken = '0;

  // dut ports
  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               cfg_we_i    = 1'b0;
  logic [CfgW-1:0]    cfg_wdata_i = '0;
  logic               in_valid_i  = 1'b0;
  logic               in_ready_o;
  logic               op_i        = OpByte;
  logic [7:0]         in_byte_i   = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic [1:0]         kind_o;
  logic [7:0]         out_byte_o;
  logic               is_header_o;
  logic [RowOutW-1:0] row_number_o;
  logic [ColOutW-1:0] column_number_o;
  logic [1:0]         status_o;
  logic               last_o;

  // tokenizer shadow state, kept in step with every accepted request
  phase_e          tk_phase      = PhStart;
  bit              tk_swallow_lf = 1'b0;
  bit              tk_hdr_seen   = 1'b0;
  logic [10:0]     tk_rows       = '0;
  int              tk_fields     = 0;
  bit              tk_nonempty   = 1'b0;
  bit              tk_halted     = 1'b0;
  logic [CfgW-1:0] tk_row_cap    = CfgRowsReset;

  token_t fresh_tokens[$];    // events caused by the request just accepted
  token_t pending_tokens[$];  // events still owed by the dut, oldest first

  // idle mix and back-pressure control
  int send_idle_pct = 6;
  int recv_idle_pct = 79;
  int hold_asks     = 0;
  int hold_seen     = 0;
  int hold_left     = 0;

  // bookkeeping
  int live_items     = 0;
  int checked_tokens = 0;
  int mismatch_count = 0;
  int cycle_count    = 0;

  // directed requests: structure chars, quoting corner cases, byte extremes
  probe_t probe_table [25] = '{
    // end of input straight after reset: nothing seen, no header
    '{OpEnd,  8'h00, 1'b1, '{KindStatus, 8'h00, 1'b0, 11'd0, 8'd0, StatusNoHeader, 1'b1}},
    // first content byte belongs to the header, column 0
    '{OpByte, 8'h61, 1'b1, '{KindByte, 8'h61, 1'b1, 11'd0, 8'd0, StatusOk, 1'b1}},
    '{OpByte, ChComma, 1'b0, NoToken},
    '{OpByte, ChQuote, 1'b0, NoToken},   // open quote
    '{OpByte, 8'h78,   1'b0, NoToken},
    '{OpByte, ChQuote, 1'b0, NoToken},
    '{OpByte, ChQuote, 1'b0, NoToken},   // doubled quote gives a literal quote
    '{OpByte, ChComma, 1'b0, NoToken},   // comma inside quotes is content
    '{OpByte, ChQuote, 1'b0, NoToken},
    '{OpByte, 8'h79,   1'b0, NoToken},   // lenient close, byte is content
    '{OpByte, ChCr,    1'b0, NoToken},
    '{OpByte, ChLf,    1'b0, NoToken},   // swallowed after cr
    '{OpByte, ChLf,    1'b0, NoToken},   // blank record, skipped
    '{OpByte, 8'hFF,   1'b0, NoToken},
    '{OpByte, 8'h00,   1'b0, NoToken},
    '{OpByte, ChLf,    1'b0, NoToken},
    '{OpByte, ChCr,    1'b0, NoToken},   // blank record ended by cr
    '{OpByte, 8'h62,   1'b0, NoToken},   // not lf, so not swallowed
    '{OpByte, ChComma, 1'b0, NoToken},
    '{OpByte, ChQuote, 1'b0, NoToken},
    '{OpByte, ChLf,    1'b0, NoToken},   // lf inside quotes is content
    // end of input inside quotes: record dropped, one data row counted so far
    '{OpEnd,  8'h00, 1'b1, '{KindStatus, 8'h00, 1'b0, 11'd1, 8'd0, StatusOpenQuote, 1'b1}},
    // parser was cleared, so again no header
    '{OpEnd,  8'h00, 1'b1, '{KindStatus, 8'h00, 1'b0, 11'd0, 8'd0, StatusNoHeader, 1'b1}},
    '{OpByte, 8'h7A,   1'b0, NoToken},
    '{OpEnd,  8'h00,   1'b0, NoToken}    // flushes the open record
  };

  csv_stream_tokenizer_unit u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .op_i            (op_i),
    .in_byte_i       (in_byte_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .kind_o          (kind_o),
    .out_byte_o      (out_byte_o),
    .is_header_o     (is_header_o),
    .row_number_o    (row_number_o),
    .column_number_o (column_number_o),
    .status_o        (status_o),
    .last_o          (last_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // tokenizer prediction
  // ---------------------------------------------------------------------------

  // row limit in force is the register clipped to the build size
  function automatic int rows_allowed();
    return (tk_row_cap < MaxRowsDefault) ? int'(tk_row_cap) : MaxRowsDefault;
  endfunction

  // header flag, row and column come from the state at the time of the event
  function automatic void add_token(kind_e k, logic [7:0] d, logic [1:0] st);
    token_t t;
    t.kind   = k;
    t.data   = d;
    t.status = st;
    t.last   = 1'b0;
    if (k == KindStatus) begin
      t.hdr = 1'b0;
      t.row = tk_rows;
      t.col = '0;
    end else begin
      t.hdr = !tk_hdr_seen;
      t.row = tk_hdr_seen ? tk_rows : '0;
      t.col = tk_fields[ColOutW-1:0];
    end
    fresh_tokens.insert(fresh_tokens.size(), t);
  endfunction

  function automatic void add_content(logic [7:0] d);
    add_token(KindByte, d, StatusOk);
    tk_nonempty = 1'b1;
  endfunction

  // record end: field and record events unless the record is one empty field;
  // the stop test runs on every record end, skipped ones too
  function automatic void close_record();
    if (tk_fields != 0 || tk_nonempty) begin
      add_token(KindField, 8'h00, StatusOk);
      add_token(KindRecord, 8'h00, StatusOk);
      if (!tk_hdr_seen) tk_hdr_seen = 1'b1;
      else if (tk_rows < rows_allowed()) tk_rows++;
    end
    if (tk_hdr_seen && tk_rows >= rows_allowed()) tk_halted = 1'b1;
    tk_fields   = 0;
    tk_nonempty = 1'b0;
    tk_phase    = PhStart;
  endfunction

  function automatic void tokenize(logic op, logic [7:0] b);
    logic [1:0] st;
    bit         skip;
    fresh_tokens.delete();
    if (op == OpEnd) begin
      st = StatusOk;
      if (!tk_halted) begin
        if (tk_phase == PhQuoted) begin
          st = StatusOpenQuote;
        end else begin
          if (tk_nonempty || tk_fields != 0) close_record();
          st = tk_hdr_seen ? StatusOk : StatusNoHeader;
        end
      end
      add_token(KindStatus, 8'h00, st);
      // everything but the row limit register goes back to reset
      tk_phase      = PhStart;
      tk_swallow_lf = 1'b0;
      tk_hdr_seen   = 1'b0;
      tk_rows       = '0;
      tk_fields     = 0;
      tk_nonempty   = 1'b0;
      tk_halted     = 1'b0;
    end else if (!tk_halted) begin
      skip = 1'b0;
      if (tk_swallow_lf) begin
        tk_swallow_lf = 1'b0;
        skip = (b == ChLf);
      end
      if (!skip) begin
        if (tk_phase == PhQuoted) begin
          if (b == ChQuote) tk_phase = PhQuoteSeen;
          else add_content(b);
        end else if (tk_phase == PhQuoteSeen && b == ChQuote) begin
          add_content(b);
          tk_phase = PhQuoted;
        end else if (b == ChComma) begin
          add_token(KindField, 8'h00, StatusOk);
          if (tk_fields < MaxCol) tk_fields++;
          tk_nonempty = 1'b0;
          tk_phase    = PhStart;
        end else if (b == ChLf) begin
          close_record();
        end else if (b == ChCr) begin
          close_record();
          tk_swallow_lf = 1'b1;
        end else if (tk_phase == PhStart && b == ChQuote) begin
          tk_phase = PhQuoted;
        end else begin
          // plain content, also the byte that closes a quote leniently
          add_content(b);
          tk_phase = PhUnquoted;
        end
      end
    end
    if (fresh_tokens.size() > 0) fresh_tokens[$].last = 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // checking
  // ---------------------------------------------------------------------------

  task automatic log_mismatch(string msg);
    $display("mismatch @%0d: %s", cycle_count, msg);
    mismatch_count++;
  endtask

  // results are sampled at the edge, before the dut updates its outputs
  always @(posedge clk_i) begin
    token_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_tokens.size() == 0) begin
        log_mismatch($sformatf("result kind %0d with nothing expected", kind_o));
      end else begin
        want = pending_tokens.pop_front();
        checked_tokens++;
        if (kind_o != want.kind)
          log_mismatch($sformatf("kind got %0d want %0d", kind_o, want.kind));
        if (out_byte_o != want.data)
          log_mismatch($sformatf("out_byte got %0h want %0h", out_byte_o, want.data));
        if (is_header_o != want.hdr)
          log_mismatch($sformatf("is_header got %0d want %0d", is_header_o, want.hdr));
        if (row_number_o != want.row)
          log_mismatch($sformatf("row_number got %0d want %0d", row_number_o, want.row));
        if (column_number_o != want.col)
          log_mismatch($sformatf("column_number got %0d want %0d", column_number_o, want.col));
        if (status_o != want.status)
          log_mismatch($sformatf("status got %0d want %0d", status_o, want.status));
        if (last_o != want.last)
          log_mismatch($sformatf("last got %0d want %0d", last_o, want.last));
      end
    end
  end

  // result side: random stalls, plus a long hold when the stimulus asks for one
  always @(posedge clk_i) begin
    if (hold_asks != hold_seen) begin
      hold_seen = hold_asks;
      hold_left = HoldCycles;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------

  // offer one request and hold it until taken; called at a rising edge
  task automatic offer_request(logic op, logic [7:0] b, logic typed, token_t want);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    op_i       <= op;
    in_byte_i  <= b;
    do @(posedge clk_i); while (!in_ready_o);
    tokenize(op, b);
    live_items++;
    // typed rows carry their own expectation, the shadow state still advances
    if (typed) pending_tokens.insert(pending_tokens.size(), want);
    else foreach (fresh_tokens[i]) pending_tokens.insert(pending_tokens.size(), fresh_tokens[i]);
  endtask

  task automatic offer_byte(logic [7:0] b);
    offer_request(OpByte, b, 1'b0, NoToken);
  endtask

  task automatic offer_end();
    offer_request(OpEnd, 8'h00, 1'b0, NoToken);
  endtask

  // drop valid, let every owed result drain, then cover a possible silent request
  task automatic settle();
    in_valid_i <= 1'b0;
    while (pending_tokens.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic set_row_cap(logic [CfgW-1:0] v);
    settle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    tk_row_cap = v;
  endtask

  // any byte that is not a structure char
  function automatic logic [7:0] plain_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(255));
    while (b == ChQuote || b == ChComma || b == ChCr || b == ChLf);
    return b;
  endfunction

  task automatic send_field();
    int shape;
    int len;
    int pick;
    logic [7:0] b;
    shape = $urandom_range(9);
    if (shape >= 1 && shape <= 5) begin
      len = $urandom_range(1, 4);
      repeat (len) offer_byte(plain_byte());
    end else if (shape > 5) begin
      offer_byte(ChQuote);
      len = $urandom_range(0, 4);
      repeat (len) begin
        pick = $urandom_range(9);
        if (pick == 0) b = ChQuote;
        else if (pick == 1) b = ChComma;
        else if (pick == 2) b = $urandom_range(1) ? ChCr : ChLf;
        else b = 8'($urandom_range(255));
        offer_byte(b);
        if (b == ChQuote) offer_byte(ChQuote);  // escaped quote
      end
      offer_byte(ChQuote);
      // now and then a lenient close: text right after the closing quote
      if ($urandom_range(4) == 0) repeat ($urandom_range(1, 2)) offer_byte(plain_byte());
    end
  endtask

  task automatic send_line_end();
    int pick;
    pick = $urandom_range(2);
    if (pick == 0) offer_byte(ChLf);
    else if (pick == 1) offer_byte(ChCr);
    else begin
      offer_byte(ChCr);
      offer_byte(ChLf);
    end
  endtask

  task automatic send_record();
    int nf;
    nf = $urandom_range(1, 4);
    for (int i = 0; i < nf; i++) begin
      if (i > 0) offer_byte(ChComma);
      send_field();
    end
    send_line_end();
  endtask

  // header plus data rows, with blank lines and several ways of ending
  task automatic send_file(int rows);
    int ending;
    for (int r = 0; r <= rows; r++) begin
      if ($urandom_range(7) == 0) send_line_end();
      send_record();
    end
    ending = $urandom_range(9);
    if (ending <= 5) begin
      offer_end();
    end else if (ending <= 7) begin
      // last record has no line end, end of input flushes it
      send_field();
      offer_byte(ChComma);
      send_field();
      offer_end();
    end else if (ending == 8) begin
      offer_byte(ChQuote);
      offer_byte(plain_byte());
      offer_end();
    end
    // otherwise the next file just runs on from here
  endtask

  task automatic send_noise(int n);
    repeat (n) offer_request(($urandom_range(19) == 0) ? OpEnd : OpByte,
                             8'($urandom_range(255)), 1'b0, NoToken);
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part, sender idles rarely and receiver often
    foreach (probe_table[i])
      offer_request(probe_table[i].op, probe_table[i].data, probe_table[i].typed,
                    probe_table[i].want);

    // register at its top value, clipped to the build size
    set_row_cap(11'h7FF);
    while (live_items < 50) send_file($urandom_range(1, 3));

    // swap the idle mix: sender gappy, receiver nearly always ready
    send_idle_pct = 79;
    recv_idle_pct = 6;

    // zero data rows: parsing stops right after the header
    set_row_cap(11'd0);
    while (live_items < 80) send_file($urandom_range(1, 3));

    // limit lowered in the middle of a data row: that row is emitted but not counted
    set_row_cap(11'd3);
    offer_end();
    repeat (3) send_record();
    send_field();
    set_row_cap(11'd1);
    offer_byte(ChComma);
    send_field();
    offer_byte(ChLf);
    send_record();
    offer_end();

    set_row_cap(11'd2);
    while (live_items < 120) send_file($urandom_range(1, 4));

    // no idling, back to the reset limit, with a long output hold to fill the block
    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_row_cap(CfgRowsReset);
    hold_asks++;
    do send_file($urandom_range(1, 3)); while (live_items < 140);
    send_noise(15);
    offer_end();

    settle();
    repeat (TailCycles) @(posedge clk_i);

    $display("%0d requests over six row-limit settings, %0d results compared",
             live_items, checked_tokens);
    $display("quoting, line endings, blank records, row stop, long output hold, 3 idle mixes");
    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
